// File: rtl/core/nnc_pkg.sv
`default_nettype none

package nnc_pkg;

    // fixed widths of the channel fields
    localparam int PORT_COORD_W = 10;
    localparam int PORT_IDX_W   = 5;
    localparam int PORT_DIST_W  = 11;

    // default sizing of the point store
    localparam int DEF_MAX_POINTS = 32;
    localparam int DEF_COORD_BITS = 10;

    // controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CUR,
        ST_SCAN,
        ST_EMIT
    } nnc_state_t;

endpackage

`default_nettype wire

// File: rtl/core/nnc_if.sv
`default_nettype none

// point channel: one transaction carries one point
interface nnc_point_if;
    import nnc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PORT_COORD_W-1:0] point_x;
    logic [PORT_COORD_W-1:0] point_y;
    logic                    last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// link channel: one transaction carries one link of the chain
interface nnc_link_if;
    import nnc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PORT_IDX_W-1:0]   from_index;
    logic [PORT_IDX_W-1:0]   to_index;
    logic [PORT_COORD_W-1:0] to_x;
    logic [PORT_COORD_W-1:0] to_y;
    logic [PORT_DIST_W-1:0]  link_distance;
    logic                    overflowed;
    logic                    last_link;

    modport source (output valid, from_index, to_index, to_x, to_y, link_distance,
                    overflowed, last_link, input ready);
    modport sink   (input valid, from_index, to_index, to_x, to_y, link_distance,
                    overflowed, last_link, output ready);
endinterface

`default_nettype wire

// File: rtl/core/manhattan_nearest_neighbour_chain.sv
// Loading: one point per cycle, ready stays high until the final point arrives.
// Chain (N points held): each link follows a scan of all N stored points, one point
// store read per cycle during the scan; N-1 links in all.
// A link waiting at the output does not hold up the scan for the next link.
// Reset (rst_n, async, active low) clears count, overflow, visited bits and control;
// the point store is not cleared, entries are only read after being written.
`default_nettype none

module manhattan_nearest_neighbour_chain #(
    parameter int MAX_POINTS = nnc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nnc_pkg::DEF_COORD_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    nnc_point_if.sink    points,
    nnc_link_if.source   links
);
    import nnc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = COORD_BITS + 1;

    nnc_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [MAX_POINTS-1:0] visited_reg, visited_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  pv_reg, pv_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic [DIST_W-1:0]     best_d_reg, best_d_next;
    logic [IDX_W-1:0]      link_cnt_reg, link_cnt_next;

    logic                  out_valid_reg;
    logic [PORT_IDX_W-1:0]   out_from_reg;
    logic [PORT_IDX_W-1:0]   out_to_reg;
    logic [PORT_COORD_W-1:0] out_x_reg;
    logic [PORT_COORD_W-1:0] out_y_reg;
    logic [PORT_DIST_W-1:0]  out_d_reg;
    logic                    out_ovf_reg;
    logic                    out_last_reg;
    logic                    out_load;
    logic                    last_now;

    logic                    full;
    logic                    wr_en;
    logic [IDX_W-1:0]        raddr;
    logic [2*COORD_BITS-1:0] rdata;
    logic [COORD_BITS-1:0]   rd_x;
    logic [COORD_BITS-1:0]   rd_y;
    logic [DIST_W-1:0]       cand_d;
    logic                    issue;
    logic                    take;

    // point store; writes only while loading, reads the scan address or else point 0
    nnc_point_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (2 * COORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({COORD_BITS'(points.point_x), COORD_BITS'(points.point_y)}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_x = rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_y = rdata[COORD_BITS-1:0];

    // distance from the current point to the candidate coming out of the store
    nnc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .ax       (cur_x_reg),
        .ay       (cur_y_reg),
        .bx       (rd_x),
        .by       (rd_y),
        .distance (cand_d)
    );

    // load side handshake
    assign full         = (count_reg == CNT_W'(MAX_POINTS));
    assign points.ready = (state_reg == ST_LOAD);
    assign wr_en        = points.valid && points.ready && !full;

    // scan read address; point 0 is read while loading for the chain start
    assign issue = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign raddr = (state_reg == ST_SCAN) ? issue_reg[IDX_W-1:0] : '0;

    // candidate beats the best so far, strict compare keeps the lowest index on ties
    assign take = pv_reg && (pidx_reg != cur_reg) && !visited_reg[pidx_reg]
                  && (!found_reg || (cand_d < best_d_reg));

    // final link when N-2 links have already been emitted before it
    assign last_now = (CNT_W'(link_cnt_reg) == (count_reg - CNT_W'(2)));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            visited_reg  <= '0;
            cur_reg      <= '0;
            issue_reg    <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            link_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            visited_reg  <= visited_next;
            cur_reg      <= cur_next;
            issue_reg    <= issue_next;
            pv_reg       <= pv_next;
            found_reg    <= found_next;
            link_cnt_reg <= link_cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        pidx_reg   <= pidx_next;
        best_reg   <= best_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        best_d_reg <= best_d_next;
    end

    // next state and control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        visited_next  = visited_reg;
        cur_next      = cur_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        issue_next    = issue_reg;
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        best_d_next   = best_d_reg;
        link_cnt_next = link_cnt_reg;
        out_load      = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (points.valid)
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (points.last_point)
                    begin
                        if (count_next >= CNT_W'(2))
                        begin
                            state_next = ST_CUR;
                        end
                        else
                        begin
                            // single point: nothing to chain, start over
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                end
            end

            ST_CUR:
            begin
                cur_next      = '0;
                cur_x_next    = rd_x;
                cur_y_next    = rd_y;
                issue_next    = '0;
                pv_next       = 1'b0;
                found_next    = 1'b0;
                link_cnt_next = '0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                pv_next   = issue;
                pidx_next = issue_reg[IDX_W-1:0];
                if (issue)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (take)
                begin
                    found_next  = 1'b1;
                    best_next   = pidx_reg;
                    best_x_next = rd_x;
                    best_y_next = rd_y;
                    best_d_next = cand_d;
                end
                if (!issue && !pv_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || links.ready)
                begin
                    out_load              = 1'b1;
                    visited_next[cur_reg] = 1'b1;
                    cur_next              = best_reg;
                    cur_x_next            = best_x_reg;
                    cur_y_next            = best_y_reg;
                    link_cnt_next         = link_cnt_reg + IDX_W'(1);
                    issue_next            = '0;
                    pv_next               = 1'b0;
                    found_next            = 1'b0;
                    if (last_now)
                    begin
                        visited_next = '0;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (links.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_from_reg <= PORT_IDX_W'(cur_reg);
            out_to_reg   <= PORT_IDX_W'(best_reg);
            out_x_reg    <= PORT_COORD_W'(best_x_reg);
            out_y_reg    <= PORT_COORD_W'(best_y_reg);
            out_d_reg    <= PORT_DIST_W'(best_d_reg);
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= last_now;
        end
    end

    assign links.valid         = out_valid_reg;
    assign links.from_index    = out_from_reg;
    assign links.to_index      = out_to_reg;
    assign links.to_x          = out_x_reg;
    assign links.to_y          = out_y_reg;
    assign links.link_distance = out_d_reg;
    assign links.overflowed    = out_ovf_reg;
    assign links.last_link     = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/nnc_point_mem.sv
`default_nettype none

module nnc_point_mem #(
    parameter int DEPTH = nnc_pkg::DEF_MAX_POINTS,
    parameter int WIDTH = 2 * nnc_pkg::DEF_COORD_BITS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import nnc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/nnc_dist.sv
`default_nettype none

module nnc_dist #(
    parameter int COORD_BITS = nnc_pkg::DEF_COORD_BITS
) (
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    output logic [COORD_BITS:0]   distance
);
    import nnc_pkg::*;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;

    // absolute differences, then their sum
    always_comb
    begin
        dx       = (ax > bx) ? (ax - bx) : (bx - ax);
        dy       = (ay > by) ? (ay - by) : (by - ay);
        distance = {1'b0, dx} + {1'b0, dy};
    end

endmodule

`default_nettype wire

// File: rtl/core/nnc_checker.sv
`default_nettype none

module nnc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pts_ready,
    input logic                            lnk_valid,
    input logic                            lnk_ready,
    input logic [nnc_pkg::PORT_DIST_W-1:0] link_distance,
    input logic                            lnk_last
);
    import nnc_pkg::*;

    // a pending link stays until taken
    a_link_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lnk_valid && !lnk_ready |=> lnk_valid)
        else $error("link dropped before transaction");

    // while a link other than the final one is held, no new point is taken
    a_chain_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
        lnk_valid && !lnk_last |-> !pts_ready)
        else $error("point channel open in the middle of a chain");

    // two coordinates of at most 1023 give at most 2046
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lnk_valid |-> (link_distance <= PORT_DIST_W'(2046)))
        else $error("link distance out of range");

endmodule

bind manhattan_nearest_neighbour_chain nnc_checker u_nnc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pts_ready     (points.ready),
    .lnk_valid     (links.valid),
    .lnk_ready     (links.ready),
    .link_distance (links.link_distance),
    .lnk_last      (links.last_link)
);

`default_nettype wire
